### hw/rtl/cfp_pkg.sv
// Shared types, constants and helpers for the command frame parser.
package cfp_pkg;

   localparam int PAYLOAD_MAX = 8;
   localparam int STORE_AW    = 3;

   localparam logic [7:0] START_MARK = 8'h3E;

   localparam logic [7:0] CMD_X = 8'h58;
   localparam logic [7:0] CMD_P = 8'h50;
   localparam logic [7:0] CMD_S = 8'h53;
   localparam logic [7:0] CMD_E = 8'h45;
   localparam logic [7:0] CMD_M = 8'h4D;
   localparam logic [7:0] CMD_C = 8'h43;
   localparam logic [7:0] CMD_W = 8'h57;
   localparam logic [7:0] CMD_R = 8'h52;
   localparam logic [7:0] CMD_L = 8'h4C;
   localparam logic [7:0] CMD_H = 8'h48;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_CMD,
      ST_LEN,
      ST_DATA,
      ST_EMIT
   } parse_state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_cmd;
      logic latch_len;
      logic clear_count;
      logic store_byte;
      logic emit_load;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_marker;
      logic is_cmd;
      logic len_big;
      logic len_zero;
      logic data_done;
      logic emit_last;
      logic out_free;
   } ctl_status_type;

   function automatic logic is_command(input logic [7:0] b);
      logic hit;
      case (b) inside
         CMD_X, CMD_P, CMD_S, CMD_E, CMD_M,
         CMD_C, CMD_W, CMD_R, CMD_L, CMD_H: hit = 1'b1;
         default:                           hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

### hw/rtl/command_frame_parser.sv
// Top level of the command frame parser: byte-serial framer with payload read-out.
// Throughput: one received byte per cycle while a frame is being parsed.
// Read-out: after a frame's final byte the framer enters its read-out state, then
// loads one beat per cycle into the output register unless the receiver stalls,
// one per payload byte (one for a zero-length frame); input stalls until the last loads.
// Reset: synchronous, active high; the framer returns to waiting for '>'.
module command_frame_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_command,
   output logic [3:0] rsp_frame_length,
   output logic [2:0] rsp_payload_index,
   output logic [7:0] rsp_payload_value,
   output logic       rsp_has_value,
   output logic       rsp_last
);

   // controller drives commands, datapath reports byte classes and read-out progress
   cfp_pkg::ctl_cmd_type    cmd;
   cfp_pkg::ctl_status_type status;

   // sequence the frame: marker, command letter, length, payload, read-out
   cfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the frame fields and payload; drive result beats from the output register
   cfp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_value (rsp_payload_value),
      .rsp_has_value     (rsp_has_value),
      .rsp_last          (rsp_last)
   );

endmodule

### hw/rtl/cfp_ctrl.sv
// Framer state machine: sequences marker, command, length, payload and read-out.
module cfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cfp_pkg::ctl_status_type status,
   output cfp_pkg::ctl_cmd_type   cmd
);

   cfp_pkg::parse_state_type state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff == cfp_pkg::ST_EMIT);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfp_pkg::ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfp_pkg::ST_WAIT: begin
            if (accept && status.is_marker) state_in = cfp_pkg::ST_CMD;
         end
         cfp_pkg::ST_CMD: begin
            if (accept) state_in = status.is_cmd ? cfp_pkg::ST_LEN : cfp_pkg::ST_WAIT;
         end
         cfp_pkg::ST_LEN: begin
            if (accept) begin
               if (status.len_big)       state_in = cfp_pkg::ST_WAIT;
               else if (status.len_zero) state_in = cfp_pkg::ST_EMIT;
               else                      state_in = cfp_pkg::ST_DATA;
            end
         end
         cfp_pkg::ST_DATA: begin
            if (accept && status.data_done) state_in = cfp_pkg::ST_EMIT;
         end
         cfp_pkg::ST_EMIT: begin
            if (status.out_free && status.emit_last) state_in = cfp_pkg::ST_WAIT;
         end
         default: state_in = cfp_pkg::ST_WAIT;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         cfp_pkg::ST_CMD: begin
            cmd.latch_cmd = accept && status.is_cmd;
         end
         cfp_pkg::ST_LEN: begin
            cmd.clear_count = accept;
            cmd.latch_len   = accept && !status.len_big;
         end
         cfp_pkg::ST_DATA: begin
            cmd.store_byte = accept;
         end
         cfp_pkg::ST_EMIT: begin
            cmd.emit_load = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### hw/rtl/cfp_datapath.sv
// Frame registers, payload store and result output register.
module cfp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_rx_byte,
   input  cfp_pkg::ctl_cmd_type   cmd,
   output cfp_pkg::ctl_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_command,
   output logic [3:0]             rsp_frame_length,
   output logic [2:0]             rsp_payload_index,
   output logic [7:0]             rsp_payload_value,
   output logic                   rsp_has_value,
   output logic                   rsp_last
);

   logic [7:0] held_command_ff;
   logic [3:0] declared_length_ff;
   logic [3:0] byte_count_ff, byte_count_in;
   logic [3:0] emit_idx_ff, emit_idx_in;
   logic [7:0] store_ff [cfp_pkg::PAYLOAD_MAX];

   logic       rsp_valid_ff;
   logic [7:0] out_command_ff;
   logic [3:0] out_length_ff;
   logic [2:0] out_index_ff;
   logic [7:0] out_value_ff;
   logic       out_has_ff;
   logic       out_last_ff;

   logic has_payload;

   assign byte_count_in = 4'(byte_count_ff + 4'd1);
   assign emit_idx_in   = 4'(emit_idx_ff + 4'd1);
   assign has_payload   = (declared_length_ff != 4'd0);

   always_comb begin
      status.is_marker = (req_rx_byte == cfp_pkg::START_MARK);
      status.is_cmd    = cfp_pkg::is_command(req_rx_byte);
      status.len_big   = (req_rx_byte > 8'(cfp_pkg::PAYLOAD_MAX));
      status.len_zero  = (req_rx_byte == 8'd0);
      status.data_done = (byte_count_in == declared_length_ff)
                         || (byte_count_in >= 4'(cfp_pkg::PAYLOAD_MAX));
      status.emit_last = !has_payload || (emit_idx_in == byte_count_ff);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_command_ff    <= '0;
         declared_length_ff <= '0;
         byte_count_ff      <= '0;
         emit_idx_ff        <= '0;
      end else begin
         if (cmd.latch_cmd) held_command_ff <= req_rx_byte;
         if (cmd.latch_len) declared_length_ff <= req_rx_byte[3:0];
         if (cmd.clear_count) begin
            byte_count_ff <= '0;
            emit_idx_ff   <= '0;
         end else begin
            if (cmd.store_byte) byte_count_ff <= byte_count_in;
            if (cmd.emit_load)  emit_idx_ff   <= emit_idx_in;
         end
      end
   end

   // payload store, written in order during the data phase
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_ff[byte_count_ff[cfp_pkg::STORE_AW-1:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_command_ff <= held_command_ff;
         out_length_ff  <= declared_length_ff;
         out_index_ff   <= emit_idx_ff[2:0];
         out_value_ff   <= has_payload ? store_ff[emit_idx_ff[2:0]] : 8'd0;
         out_has_ff     <= has_payload;
         out_last_ff    <= status.emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = out_command_ff;
   assign rsp_frame_length  = out_length_ff;
   assign rsp_payload_index = out_index_ff;
   assign rsp_payload_value = out_value_ff;
   assign rsp_has_value     = out_has_ff;
   assign rsp_last          = out_last_ff;

endmodule

### dv/command_frame_parser_test.sv
// Self-checking testbench for the command frame parser: directed and random byte streams.
module command_frame_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One read-out beat, field for field as the block presents it.
   typedef struct packed {
      logic [7:0] command;
      logic [3:0] frame_length;
      logic [2:0] payload_index;
      logic [7:0] payload_value;
      logic       has_value;
      logic       last;
   } frame_beat_type;

   // Command letters that the framer accepts after the marker.
   localparam logic [7:0] LETTERS [10] = '{cfp_pkg::CMD_X, cfp_pkg::CMD_P, cfp_pkg::CMD_S,
                                           cfp_pkg::CMD_E, cfp_pkg::CMD_M, cfp_pkg::CMD_C,
                                           cfp_pkg::CMD_W, cfp_pkg::CMD_R, cfp_pkg::CMD_L,
                                           cfp_pkg::CMD_H};

   function automatic bit is_letter(logic [7:0] b);
      foreach (LETTERS[i])
         if (LETTERS[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   // Tracks the framer from the accepted byte stream and holds the beats it owes.
   class frame_checker;
      frame_beat_type           expected_beats[$];
      int                       errors;
      cfp_pkg::parse_state_type phase;
      logic [7:0]               held_cmd;
      logic [3:0]               held_len;
      logic [3:0]               stored;
      logic [7:0]               payload[cfp_pkg::PAYLOAD_MAX];

      function new();
         errors   = 0;
         phase    = cfp_pkg::ST_WAIT;
         held_cmd = '0;
         held_len = '0;
         stored   = '0;
         foreach (payload[i]) payload[i] = '0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // Advance the framer by one accepted byte; queue the beats a completed frame owes.
      function void take_rx_byte(logic [7:0] b);
         frame_beat_type beat;
         case (phase)
            cfp_pkg::ST_WAIT: begin
               if (b == cfp_pkg::START_MARK) phase = cfp_pkg::ST_CMD;
            end
            cfp_pkg::ST_CMD: begin
               if (is_letter(b)) begin
                  held_cmd = b;
                  phase    = cfp_pkg::ST_LEN;
               end else begin
                  phase = cfp_pkg::ST_WAIT;
               end
            end
            cfp_pkg::ST_LEN: begin
               stored = '0;
               if (b > cfp_pkg::PAYLOAD_MAX) begin
                  phase = cfp_pkg::ST_WAIT;
               end else if (b == 0) begin
                  held_len = '0;
                  beat = '{held_cmd, 4'd0, 3'd0, 8'd0, 1'b0, 1'b1};
                  expected_beats.push_back(beat);
                  phase = cfp_pkg::ST_WAIT;
               end else begin
                  held_len = b[3:0];
                  phase    = cfp_pkg::ST_DATA;
               end
            end
            default: begin
               if (stored < cfp_pkg::PAYLOAD_MAX) payload[stored[2:0]] = b;
               stored = stored + 4'd1;
               if (stored == held_len || stored >= cfp_pkg::PAYLOAD_MAX) begin
                  for (int i = 0; i < stored && i < cfp_pkg::PAYLOAD_MAX; i++) begin
                     beat = '{held_cmd, held_len, 3'(i), payload[i], 1'b1,
                              (i + 1 == stored)};
                     expected_beats.push_back(beat);
                  end
                  phase = cfp_pkg::ST_WAIT;
               end
            end
         endcase
      endfunction

      task check_beat(frame_beat_type got);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
            return;
         end
         want = expected_beats.pop_front();
         if (got.command != want.command)
            report_mismatch($sformatf("command %h want %h", got.command, want.command));
         if (got.frame_length != want.frame_length)
            report_mismatch($sformatf("frame_length %0d want %0d",
                                      got.frame_length, want.frame_length));
         if (got.payload_index != want.payload_index)
            report_mismatch($sformatf("payload_index %0d want %0d",
                                      got.payload_index, want.payload_index));
         if (got.payload_value != want.payload_value)
            report_mismatch($sformatf("payload_value %h want %h",
                                      got.payload_value, want.payload_value));
         if (got.has_value != want.has_value)
            report_mismatch($sformatf("has_value %b want %b", got.has_value, want.has_value));
         if (got.last != want.last)
            report_mismatch($sformatf("last %b want %b", got.last, want.last));
      endtask
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_command;
   logic [3:0] rsp_frame_length;
   logic [2:0] rsp_payload_index;
   logic [7:0] rsp_payload_value;
   logic       rsp_has_value;
   logic       rsp_last;

   frame_checker checker_h = new();

   // When set, the sender leaves no gaps and the receiver stops stalling once its current stall run ends.
   bit calm = 1'b0;
   int sent = 0;
   int stall_left = 0;

   command_frame_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_value (rsp_payload_value),
      .rsp_has_value     (rsp_has_value),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   // Mostly back-to-back, often a short pause, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one byte and hold it until the block takes it. Returns in the time
   // step of the accepting edge, so a following byte with no gap keeps valid high.
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   function automatic logic [7:0] pick_letter();
      return LETTERS[$urandom_range(0, 9)];
   endfunction

   function automatic logic [7:0] pick_non_letter();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_letter(b));
      return b;
   endfunction

   // A well-formed frame with random command, length and content. Lengths lean
   // on the extremes; payload sometimes carries the marker as plain data.
   task automatic send_good_frame();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 0;
      else if (r < 25) len = cfp_pkg::PAYLOAD_MAX;
      else             len = $urandom_range(1, cfp_pkg::PAYLOAD_MAX - 1);
      send_byte(cfp_pkg::START_MARK);
      send_byte(pick_letter());
      send_byte(8'(len));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) send_byte(cfp_pkg::START_MARK);
         else                           send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Monitor both channels at each edge: note accepted input bytes first, then
   // check any accepted result, then decide the receiver stall for the next cycle.
   always @(posedge clock) begin
      frame_beat_type got;
      if (!reset) begin
         if (req_valid && !req_stall) checker_h.take_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_command, rsp_frame_length, rsp_payload_index,
                    rsp_payload_value, rsp_has_value, rsp_last};
            checker_h.check_beat(got);
         end
      end
      if (stall_left != 0) begin
         stall_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else if (r < 92) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(9, 39);
         end
      end
   end

   initial begin
      // Directed bytes: noise before the marker, a full-length frame with edge
      // payload values and a marker inside it, a zero-length frame, lengths just
      // over the limit and at the top of the byte, a marker taken as a bad
      // command (the letter after it must not start a frame), a one-byte frame.
      logic [7:0] directed[$] = '{
         8'h00, 8'hFF,
         cfp_pkg::START_MARK, cfp_pkg::CMD_X, 8'd8,
         8'h00, 8'hFF, cfp_pkg::START_MARK, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F,
         cfp_pkg::START_MARK, cfp_pkg::CMD_P, 8'd0,
         cfp_pkg::START_MARK, cfp_pkg::CMD_S, 8'd9,
         cfp_pkg::START_MARK, cfp_pkg::CMD_E, 8'hFF,
         cfp_pkg::START_MARK, cfp_pkg::START_MARK, cfp_pkg::CMD_M,
         cfp_pkg::START_MARK, cfp_pkg::CMD_M, 8'd1, 8'h3C
      };
      int r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i]);

      // Random part: mostly good frames, the rest noise and broken frames.
      while (sent < 250) begin
         calm = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_good_frame();
         end else if (r < 78) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (r < 86) begin
            send_byte(cfp_pkg::START_MARK);
            send_byte(pick_non_letter());
         end else if (r < 94) begin
            send_byte(cfp_pkg::START_MARK);
            send_byte(pick_letter());
            send_byte(8'($urandom_range(cfp_pkg::PAYLOAD_MAX + 1, 255)));
         end else begin
            // Lone marker: whatever comes next is taken as the command.
            send_byte(cfp_pkg::START_MARK);
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain: wait for every owed beat, then watch a while for strays.
      do @(posedge clock); while (checker_h.pending() != 0);
      repeat (40) @(posedge clock);

      if (checker_h.errors == 0 && checker_h.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
